// File: hdl/umd_pkg.sv
package umd_pkg;

  // Default sensor count and its supported range is 1..16
  localparam int SENSOR_COUNT_DEF = 3;

  // Valid distance window in cm
  localparam int MIN_CM = 2;
  localparam int MAX_CM = 400;

  // Register reset values
  localparam logic [8:0] MAX_DIST_RST = 9'd400;
  localparam logic [8:0] THRESH_RST   = 9'd10;

  // cm = floor(us * 343 / 20000).
  // The divide by 20000 is a multiply by ceil(2^38 / 20000) and a shift by 38.
  // This is exact for every product of a 15-bit echo and 343.
  localparam int          SCALE_MUL   = 343;
  localparam int          RECIP_SHIFT = 38;
  localparam logic [23:0] RECIP       = 24'd13743896;

  // Command queue depth, must be a power of two
  localparam int QDEPTH = 4;

  typedef enum logic [2:0] {
    ST_COMPARED = 3'd0,
    ST_INVALID  = 3'd1,
    ST_BEYOND   = 3'd2,
    ST_BASELINE = 3'd3,
    ST_BADINDEX = 3'd4
  } umd_status_t;

  typedef enum logic [1:0] {
    CMD_MEASURE,
    CMD_BEYOND,
    CMD_INVALID,
    CMD_BADIDX
  } umd_kind_t;

  typedef enum logic {
    REG_MAX_DIST  = 1'b0,
    REG_THRESHOLD = 1'b1
  } umd_reg_t;

  typedef struct packed {
    logic [3:0]  sensor;
    logic [14:0] echo_us;
  } umd_in_t;

  typedef struct packed {
    logic        motion;
    logic [8:0]  distance_cm;
    umd_status_t status;
  } umd_out_t;

  // Classified reading handed from front end to back end
  typedef struct packed {
    umd_kind_t  kind;
    logic [3:0] sensor;
    logic [8:0] dist_cm;
  } umd_cmd_t;

  typedef struct packed {
    logic [8:0] max_dist;
    logic [8:0] threshold;
  } umd_cfg_t;

endpackage

// File: hdl/umd_front.sv
module umd_front #(
  parameter int SENSOR_COUNT = umd_pkg::SENSOR_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  umd_pkg::umd_in_t   in_data,
  input  umd_pkg::umd_cfg_t  cfg,
  input  logic               q_full,
  output logic               q_push,
  output umd_pkg::umd_cmd_t  q_cmd
);
  import umd_pkg::*;

  logic        s1_valid_r;
  logic [3:0]  s1_sensor_r;
  logic [23:0] s1_prod_r;
  logic [47:0] scaled;
  logic [9:0]  dist10;
  logic        bad_idx;

  // Stage 1: scale the echo time by 343
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sensor_r <= in_data.sensor;
      s1_prod_r   <= 24'(in_data.echo_us) * 24'(SCALE_MUL);
    end
  end

  // Reciprocal multiply gives the distance in cm
  assign scaled  = 48'(s1_prod_r) * 48'(RECIP);
  assign dist10  = scaled[RECIP_SHIFT +: 10];
  assign bad_idx = {1'b0, s1_sensor_r} >= 5'(SENSOR_COUNT);

  // Classify the reading
  always_comb begin
    q_cmd.sensor  = s1_sensor_r;
    q_cmd.dist_cm = dist10[8:0];
    if (bad_idx) begin
      q_cmd.kind    = CMD_BADIDX;
      q_cmd.dist_cm = '0;
    end else if (dist10 < 10'(MIN_CM) || dist10 > 10'(MAX_CM)) begin
      q_cmd.kind    = CMD_INVALID;
      q_cmd.dist_cm = '0;
    end else if (dist10 > {1'b0, cfg.max_dist}) begin
      q_cmd.kind = CMD_BEYOND;
    end else begin
      q_cmd.kind = CMD_MEASURE;
    end
  end

  assign q_push   = s1_valid_r && !q_full;
  assign in_ready = !s1_valid_r || !q_full;

endmodule

// File: hdl/umd_queue.sv
module umd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  umd_pkg::umd_cmd_t  din,
  output logic               full,
  input  logic               pop,
  output umd_pkg::umd_cmd_t  dout,
  output logic               empty
);
  import umd_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  umd_cmd_t           mem_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  assign dout  = mem_r[rd_ptr_r];
  assign full  = cnt_r == CNT_W'(QDEPTH);
  assign empty = cnt_r == '0;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue pop while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QDEPTH))
    else $error("queue count beyond depth");

endmodule

// File: hdl/umd_back.sv
module umd_back #(
  parameter int SENSOR_COUNT = umd_pkg::SENSOR_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  umd_pkg::umd_cfg_t  cfg,
  input  logic               q_empty,
  input  umd_pkg::umd_cmd_t  q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output umd_pkg::umd_out_t  out_data
);
  import umd_pkg::*;

  localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

  logic [8:0]              last_dist_r [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0] last_valid_r;
  logic                    out_valid_r;
  umd_out_t                out_data_r;
  umd_out_t                res;
  logic [IDX_W-1:0]        idx;
  logic [8:0]              prev;
  logic [8:0]              change;
  logic                    stores;

  assign q_pop  = !q_empty && (!out_valid_r || out_ready);
  assign idx    = q_cmd.sensor[IDX_W-1:0];
  assign prev   = last_dist_r[idx];
  assign change = (q_cmd.dist_cm >= prev) ? (q_cmd.dist_cm - prev)
                                          : (prev - q_cmd.dist_cm);
  assign stores = (q_cmd.kind == CMD_BEYOND) || (q_cmd.kind == CMD_MEASURE);

  // Build the result from the command and the stored baseline
  always_comb begin
    res.motion      = 1'b0;
    res.distance_cm = q_cmd.dist_cm;
    case (q_cmd.kind)
      CMD_BADIDX: begin
        res.status = ST_BADINDEX;
      end
      CMD_INVALID: begin
        res.status = ST_INVALID;
      end
      CMD_BEYOND: begin
        res.status = ST_BEYOND;
      end
      CMD_MEASURE: begin
        if (!last_valid_r[idx]) begin
          res.status = ST_BASELINE;
        end else begin
          res.status = ST_COMPARED;
          res.motion = change >= cfg.threshold;
        end
      end
      default: begin
        res.status = ST_INVALID;
      end
    endcase
  end

  // Per-sensor baseline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_valid_r <= '0;
    end else if (q_pop && stores) begin
      last_valid_r[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && stores) begin
      last_dist_r[idx] <= q_cmd.dist_cm;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_baseline_set: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && stores |=> last_valid_r[$past(idx)])
    else $error("stored reading left sensor without baseline");
  a_motion_only_compared: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.motion |-> out_data_r.status == ST_COMPARED)
    else $error("motion flagged outside a comparison");

endmodule

// File: hdl/ultrasonic_motion_detector_core.sv
// Ultrasonic motion detector: each input transaction carries a sensor index and
// an echo time in microseconds. The block answers with one result transaction
// (motion flag, distance in cm, status). It sustains one transaction per clock
// while results are accepted. A reading passes the scaling stage register,
// then a four-entry command queue, then the baseline update stage that writes
// the output register. The queue sits between the two stages, so input keeps
// flowing while a result waits, until the queue fills. Write the max_distance
// (index 0) and movement_threshold (index 1) registers only while no
// transaction is in flight.
module ultrasonic_motion_detector_core #(
  parameter int SENSOR_COUNT = umd_pkg::SENSOR_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  umd_pkg::umd_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output umd_pkg::umd_out_t  out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [8:0]         cfg_wdata
);
  import umd_pkg::*;

  umd_cfg_t cfg_r;
  umd_cmd_t push_cmd;
  umd_cmd_t pop_cmd;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_dist  <= MAX_DIST_RST;
      cfg_r.threshold <= THRESH_RST;
    end else if (cfg_we) begin
      case (umd_reg_t'(cfg_index))
        REG_MAX_DIST:  cfg_r.max_dist  <= cfg_wdata;
        REG_THRESHOLD: cfg_r.threshold <= cfg_wdata;
        default: ;
      endcase
    end
  end

  umd_front #(.SENSOR_COUNT(SENSOR_COUNT)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  umd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (push_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (pop_cmd),
    .empty (q_empty)
  );

  umd_back #(.SENSOR_COUNT(SENSOR_COUNT)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: verif/ultrasonic_motion_detector_checker.sv
`timescale 1ns / 1ps
module ultrasonic_motion_detector_checker #(
  parameter int SENSORS = umd_pkg::SENSOR_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  umd_pkg::umd_in_t     in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  umd_pkg::umd_out_t    out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [8:0]           cfg_wdata,
  output int unsigned          mismatches,
  output int unsigned          outstanding
);
  import umd_pkg::*;

  // echo time to cm: floor(us * 343 / 20000)
  localparam int unsigned CM_DIVISOR = 20000;

  // shadow copy of the block's registers and per-sensor store
  logic [8:0]  max_cm;
  logic [8:0]  thresh_cm;
  logic [8:0]  stored_cm [SENSORS];
  logic        has_base [SENSORS];
  umd_out_t    pending_results [$];
  int unsigned err_count = 0;

  // expected result of one reading; updates the shadow store
  function automatic umd_out_t predict_reading(umd_in_t rd);
    umd_out_t    res;
    int unsigned cm;
    int unsigned delta;
    res.motion      = 1'b0;
    res.distance_cm = '0;
    res.status      = ST_INVALID;
    cm = (32'(rd.echo_us) * SCALE_MUL) / CM_DIVISOR;
    if (rd.sensor >= SENSORS) begin
      res.status = ST_BADINDEX;
    end else if (rd.echo_us == '0 || cm < MIN_CM || cm > MAX_CM) begin
      res.status = ST_INVALID;
    end else if (cm > max_cm) begin
      stored_cm[rd.sensor] = cm[8:0];
      has_base[rd.sensor]  = 1'b1;
      res.distance_cm      = cm[8:0];
      res.status           = ST_BEYOND;
    end else if (!has_base[rd.sensor]) begin
      stored_cm[rd.sensor] = cm[8:0];
      has_base[rd.sensor]  = 1'b1;
      res.distance_cm      = cm[8:0];
      res.status           = ST_BASELINE;
    end else begin
      delta = (cm >= stored_cm[rd.sensor]) ? cm - stored_cm[rd.sensor]
                                           : stored_cm[rd.sensor] - cm;
      stored_cm[rd.sensor] = cm[8:0];
      res.motion           = (delta >= thresh_cm);
      res.distance_cm      = cm[8:0];
      res.status           = ST_COMPARED;
    end
    return res;
  endfunction

  task automatic flag_mismatch(string what, umd_out_t want, umd_out_t got);
    err_count++;
    if (err_count <= 10)
      $display({"checker: %s at %0t: expected motion=%0b dist=%0d status=%0d, ",
                "got motion=%0b dist=%0d status=%0d"},
               what, $realtime, want.motion, want.distance_cm, want.status,
               got.motion, got.distance_cm, got.status);
  endtask

  // watch config writes, result transactions and input transactions
  always @(posedge clk) begin
    umd_out_t want;
    if (!rst_n) begin
      max_cm    = MAX_DIST_RST;
      thresh_cm = THRESH_RST;
      for (int i = 0; i < SENSORS; i++) has_base[i] = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (umd_reg_t'(cfg_index))
          REG_MAX_DIST:  max_cm = cfg_wdata;
          REG_THRESHOLD: thresh_cm = cfg_wdata;
          default: ;
        endcase
      end
      // results lag inputs by at least one stage, so pop before push
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("unexpected result", '0, out_data);
        end else begin
          want = pending_results.pop_front();
          if (out_data.motion !== want.motion ||
              out_data.distance_cm !== want.distance_cm ||
              out_data.status !== want.status)
            flag_mismatch("wrong result", want, out_data);
        end
      end
      if (in_valid && in_ready) pending_results.push_back(predict_reading(in_data));
    end
    mismatches  <= err_count;
    outstanding <= pending_results.size();
  end

endmodule

// File: verif/ultrasonic_motion_detector_core_test.sv
`timescale 1ns / 1ps
module ultrasonic_motion_detector_core_test;
  import umd_pkg::*;

  localparam int SENSORS         = SENSOR_COUNT_DEF;
  localparam int IDLE_LIMIT      = 2000;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  umd_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  umd_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [8:0]  cfg_wdata = '0;
  int unsigned mismatches;
  int unsigned outstanding;

  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  bit          steady_out = 1'b0;
  bit          sender_steady = 1'b0;
  int unsigned cur_thresh = THRESH_RST;
  int unsigned last_sent_cm [SENSORS];

  always #1 clk = ~clk;

  ultrasonic_motion_detector_core #(.SENSOR_COUNT(SENSORS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ultrasonic_motion_detector_checker #(.SENSORS(SENSORS)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // any echo time that converts to the given cm
  function automatic logic [14:0] echo_for_cm(int unsigned cm);
    int unsigned lo;
    int unsigned hi;
    lo = (cm * 20000 + 342) / 343;
    hi = ((cm + 1) * 20000 + 342) / 343 - 1;
    return 15'($urandom_range(hi, lo));
  endfunction

  function automatic umd_in_t reading(int unsigned s, int unsigned echo);
    umd_in_t rd;
    rd.sensor  = 4'(s);
    rd.echo_us = 15'(echo);
    return rd;
  endfunction

  // random reading: most often a step around the last distance sent to the sensor
  function automatic umd_in_t random_reading();
    int unsigned s;
    int unsigned r;
    int unsigned span;
    int          cm;
    umd_in_t     rd;
    s  = ($urandom_range(0, 9) == 0) ? $urandom_range(SENSORS, 15)
                                     : $urandom_range(0, SENSORS - 1);
    r  = $urandom_range(0, 99);
    cm = -1;
    if (r < 45) begin
      span = cur_thresh + 3;
      cm = int'(last_sent_cm[s % SENSORS]) + int'($urandom_range(0, 2 * span)) - int'(span);
      if (cm < MIN_CM) cm = MIN_CM;
      if (cm > MAX_CM) cm = MAX_CM;
    end else if (r < 70) begin
      cm = $urandom_range(MIN_CM, MAX_CM);
    end else if (r < 80) begin
      case ($urandom_range(0, 3))
        0: cm = MIN_CM - 1;
        1: cm = MIN_CM;
        2: cm = MAX_CM;
        default: cm = MAX_CM + 1;
      endcase
    end
    if (cm >= 0) begin
      rd = reading(s, echo_for_cm(cm));
      if (s < SENSORS && cm >= MIN_CM && cm <= MAX_CM) last_sent_cm[s] = cm;
    end else if (r < 88) begin
      rd = reading(s, 0);
    end else begin
      rd = reading(s, $urandom_range(0, 32767));
    end
    return rd;
  endfunction

  // one input transaction, then an optional gap; valid stays up when no gap
  task automatic send_reading(umd_in_t rd);
    int unsigned gap;
    in_data  <= rd;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = sender_steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender until every expected result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_regs(logic [8:0] max_cm, logic [8:0] thresh);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_DIST;
    cfg_wdata <= max_cm;
    @(posedge clk);
    cfg_index <= REG_THRESHOLD;
    cfg_wdata <= thresh;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_thresh = thresh;
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    if (steady_out) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < 30) stall_left <= pick_gap();
    end
  end

  // watchdog: cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < SENSORS; i++) last_sent_cm[i] = 200;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: range limits, bad index, baseline and threshold edges
    send_reading(reading(0, 0));
    send_reading(reading(0, 116));
    send_reading(reading(0, 117));
    send_reading(reading(0, 32767));
    send_reading(reading(0, 30000));
    send_reading(reading(0, echo_for_cm(MAX_CM + 1)));
    send_reading(reading(15, 32767));
    send_reading(reading(SENSORS, echo_for_cm(100)));
    send_reading(reading(1, echo_for_cm(MAX_CM)));
    send_reading(reading(1, echo_for_cm(MAX_CM)));
    send_reading(reading(1, echo_for_cm(390)));
    send_reading(reading(1, echo_for_cm(399)));
    send_reading(reading(0, echo_for_cm(12)));
    send_reading(reading(0, echo_for_cm(3)));
    wait_idle();

    // directed: beyond max with and without a baseline, zero threshold
    write_regs(9'd150, 9'd0);
    send_reading(reading(2, echo_for_cm(300)));
    send_reading(reading(2, echo_for_cm(100)));
    send_reading(reading(2, echo_for_cm(100)));
    send_reading(reading(0, echo_for_cm(151)));
    send_reading(reading(0, echo_for_cm(150)));
    send_reading(reading(1, echo_for_cm(MAX_CM)));
    send_reading(reading(1, 23324));
    wait_idle();

    // random phases, each under its own register setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: write_regs(MAX_DIST_RST, THRESH_RST);
        1: write_regs(9'd0, 9'd0);
        2: write_regs(9'd511, 9'd511);
        3: write_regs(9'd400, 9'd1);
        default: write_regs(9'($urandom_range(20, 400)), 9'($urandom_range(1, 30)));
      endcase
      sender_steady = (ph == 2 || ph == 5);
      steady_out    = (ph == 2 || ph == 6);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 3 && n == ITEMS_PER_PHASE / 2) wait_idle();
        send_reading(random_reading());
      end
      wait_idle();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
